// ===== sv/cfsk_pkg.sv =====
// cfsk_pkg: shared types and constants for the cassette fsk record decoder
// no dependencies; used by cfsk_step and cassette_fsk_record_decoder
`timescale 1ns / 1ps

package cfsk_pkg;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2
  } cfsk_op_t;

  typedef enum logic [0:0] {
    REG_CYCLE_THRESHOLD = 1'b0,
    REG_IDLE_TIMEOUT    = 1'b1
  } cfsk_reg_t;

  localparam logic [7:0]  PORT_ID        = 8'hFF;
  localparam int          LINE_BIT       = 0;
  localparam int          THR_W          = 16;
  localparam int          IDLE_W         = 24;
  localparam logic [15:0] THRESHOLD_RST  = 16'd2600;
  localparam logic [23:0] IDLE_RST       = 24'd100000;
  localparam logic [3:0]  BITS_PER_BYTE  = 4'd8;

  // control state of the decoder, time stamp kept separately
  typedef struct packed {
    logic       recording;
    logic       prev_line;
    logic       armed;
    logic [1:0] cycle_count;
    logic [7:0] shift_byte;
    logic [2:0] bit_count;
  } cfsk_ctl_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data_byte;
    logic       padded;
  } cfsk_res_t;

endpackage

// ===== sv/cfsk_step.sv =====
// cfsk_step: combinational next-state and result logic for one transaction
// depends on cfsk_pkg
`timescale 1ns / 1ps

module cfsk_step import cfsk_pkg::*; #(
  parameter int TIME_BITS = 32
) (
  input  logic [1:0]           opcode,
  input  logic [7:0]           port_number,
  input  logic [7:0]           port_value,
  input  logic [31:0]          time_stamp,
  input  logic [THR_W-1:0]     cycle_threshold,
  input  logic [IDLE_W-1:0]    idle_timeout,
  input  cfsk_ctl_t            ctl_i,
  input  logic [TIME_BITS-1:0] last_i,
  output cfsk_ctl_t            ctl_o,
  output logic [TIME_BITS-1:0] last_o,
  output cfsk_res_t            res
);

  logic [63:0]          stamp_ext;
  logic [TIME_BITS-1:0] now;
  logic [TIME_BITS-1:0] interval;
  logic [TIME_BITS-1:0] thr_ext;
  logic [TIME_BITS-1:0] idle_ext;
  logic                 line;
  logic [3:0]           bit_sum;
  logic [7:0]           shifted;
  logic [3:0]           pad_amt;
  logic                 push_req;
  logic                 push_val;
  logic                 flush;

  assign stamp_ext = {32'd0, time_stamp};
  assign now       = stamp_ext[TIME_BITS-1:0];
  assign interval  = now - last_i;
  assign thr_ext   = {{(TIME_BITS-THR_W){1'b0}}, cycle_threshold};
  assign idle_ext  = {{(TIME_BITS-IDLE_W){1'b0}}, idle_timeout};
  assign line      = port_value[LINE_BIT];
  assign bit_sum   = {1'b0, ctl_i.bit_count} + 4'd1;

  always_comb begin
    ctl_o    = ctl_i;
    last_o   = last_i;
    res      = '0;
    push_req = 1'b0;
    push_val = 1'b0;
    flush    = 1'b0;
    pad_amt  = '0;

    unique case (opcode)
      OP_WRITE: begin
        if (port_number == PORT_ID) begin
          if (ctl_i.recording && line && !ctl_i.prev_line) begin
            last_o = now;
            if (!ctl_i.armed) begin
              // first cycle only arms
              ctl_o.armed       = 1'b1;
              ctl_o.cycle_count = 2'd1;
            end else if (interval > idle_ext) begin
              ctl_o.cycle_count = 2'd1;
            end else if (interval > thr_ext) begin
              // long cycle: lone pending cycle is a zero
              push_req          = (ctl_i.cycle_count == 2'd1);
              ctl_o.cycle_count = 2'd1;
            end else if (ctl_i.cycle_count == 2'd1) begin
              // second short cycle is a one
              push_req          = 1'b1;
              push_val          = 1'b1;
              ctl_o.cycle_count = 2'd0;
            end else begin
              ctl_o.cycle_count = ctl_i.cycle_count + 2'd1;
            end
          end
          ctl_o.prev_line = line;
        end
      end
      OP_START: begin
        ctl_o.recording   = 1'b1;
        ctl_o.armed       = 1'b0;
        ctl_o.cycle_count = 2'd0;
        ctl_o.shift_byte  = '0;
        ctl_o.bit_count   = '0;
        last_o            = '0;
      end
      OP_STOP: begin
        if (ctl_i.recording) begin
          push_req = (ctl_i.cycle_count == 2'd1);
          flush    = 1'b1;
        end
        ctl_o.recording = 1'b0;
      end
      default: ;
    endcase

    shifted = {ctl_i.shift_byte[6:0], push_val};

    // shift in one bit, msb first
    if (push_req) begin
      if (bit_sum == BITS_PER_BYTE) begin
        res.valid        = 1'b1;
        res.data_byte    = shifted;
        res.padded       = 1'b0;
        ctl_o.shift_byte = '0;
        ctl_o.bit_count  = '0;
      end else begin
        ctl_o.shift_byte = shifted;
        ctl_o.bit_count  = bit_sum[2:0];
      end
    end

    // partial byte at stop, zero padded on the right
    if (flush) begin
      pad_amt = BITS_PER_BYTE - {1'b0, ctl_o.bit_count};
      if (!res.valid && ctl_o.bit_count != 3'd0) begin
        res.valid     = 1'b1;
        res.data_byte = ctl_o.shift_byte << pad_amt;
        res.padded    = 1'b1;
      end
      ctl_o.shift_byte = '0;
      ctl_o.bit_count  = '0;
    end
  end

endmodule

// ===== sv/cassette_fsk_record_decoder.sv =====
// cassette_fsk_record_decoder: top level, input register, decoder state, result register
// depends on cfsk_pkg and cfsk_step
`timescale 1ns / 1ps

// channel   direction  handshake            payload
// in        input      in_valid / in_stall  in_opcode, in_port_number, in_port_value,
//                                           in_time_stamp
// out       output     out_valid/out_stall  out_data_byte, out_padded
// cfg       input      cfg_we               cfg_index, cfg_wdata
//
// one transaction per cycle sustained unless out_stall holds a result; out_valid rises once
// a result has passed the input register, then the decode logic into the result register
// rst_n is synchronous: clears recording state and reloads register defaults
// out_stall only holds the input register when it carries a result;
// transactions that give no result still move on

module cassette_fsk_record_decoder import cfsk_pkg::*; #(
  parameter int TIME_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_opcode,
  input  logic [7:0]          in_port_number,
  input  logic [7:0]          in_port_value,
  input  logic [31:0]         in_time_stamp,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_data_byte,
  output logic                out_padded,
  input  logic                cfg_we,
  input  logic [0:0]          cfg_index,
  input  logic [IDLE_W-1:0]   cfg_wdata
);

  // configuration registers
  logic [THR_W-1:0]     cycle_threshold_r;
  logic [IDLE_W-1:0]    idle_timeout_r;

  // input register
  logic                 s1_valid_r, s1_valid_nxt;
  logic [1:0]           s1_opcode_r;
  logic [7:0]           s1_port_number_r;
  logic [7:0]           s1_port_value_r;
  logic [31:0]          s1_time_stamp_r;

  // decoder state
  cfsk_ctl_t            ctl_r, ctl_nxt;
  logic [TIME_BITS-1:0] last_r, last_nxt;

  // result register
  logic                 out_valid_r, out_valid_nxt;
  logic [7:0]           out_data_byte_r;
  logic                 out_padded_r;

  cfsk_res_t            res;
  logic                 in_accept;
  logic                 out_blocked;
  logic                 s1_adv;

  // config writes land directly; the user must issue them only while idle, the block does not enforce this
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cycle_threshold_r <= THRESHOLD_RST;
      idle_timeout_r    <= IDLE_RST;
    end else if (cfg_we) begin
      unique case (cfsk_reg_t'(cfg_index))
        REG_CYCLE_THRESHOLD: cycle_threshold_r <= cfg_wdata[THR_W-1:0];
        REG_IDLE_TIMEOUT:    idle_timeout_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  cfsk_step #(
    .TIME_BITS(TIME_BITS)
  ) u_step (
    .opcode          (s1_opcode_r),
    .port_number     (s1_port_number_r),
    .port_value      (s1_port_value_r),
    .time_stamp      (s1_time_stamp_r),
    .cycle_threshold (cycle_threshold_r),
    .idle_timeout    (idle_timeout_r),
    .ctl_i           (ctl_r),
    .last_i          (last_r),
    .ctl_o           (ctl_nxt),
    .last_o          (last_nxt),
    .res             (res)
  );

  // the held transaction only waits when it has a result and the result slot is taken
  assign out_blocked = out_valid_r && out_stall;
  assign s1_adv      = s1_valid_r && (!res.valid || !out_blocked);
  assign in_stall    = s1_valid_r && !s1_adv;
  assign in_accept   = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv && res.valid) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      ctl_r       <= '0;
      last_r      <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_adv) begin
        ctl_r  <= ctl_nxt;
        last_r <= last_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_opcode_r      <= in_opcode;
      s1_port_number_r <= in_port_number;
      s1_port_value_r  <= in_port_value;
      s1_time_stamp_r  <= in_time_stamp;
    end
    if (s1_adv && res.valid) begin
      out_data_byte_r <= res.data_byte;
      out_padded_r    <= res.padded;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_data_byte = out_data_byte_r;
  assign out_padded    = out_padded_r;

`ifndef SYNTHESIS
  // nothing is held in the shift register outside recording
  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !ctl_r.recording |-> (ctl_r.bit_count == 3'd0 && ctl_r.shift_byte == 8'd0))
    else $error("partial byte left over while not recording");

  // a pair of short cycles always folds back to zero
  a_cycle_count: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_r.cycle_count != 2'd3)
    else $error("cycle count reached an unreachable value");

  // a padded byte has at least one zero fill bit at the bottom
  a_pad_lsb: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_padded) |-> !out_data_byte[0])
    else $error("padded byte without zero fill");

  // backpressure only comes from a held transaction
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && res.valid && out_blocked))
    else $error("input stalled without a blocked result");
`endif

endmodule
